FILE: rtl/software_timer_table_defines.svh
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define STT_ASSERT_IMP(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define STT_ASSERT_NXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/stt_pkg.sv
package stt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS   = 16;
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

   localparam int WINDOW_DAYS   = 10;
   localparam int HOURS_PER_DAY = 24;
   localparam int SECS_PER_HOUR = 3600;
   localparam int MS_PER_SEC    = 1000;
   localparam logic [31:0] WINDOW_RESET =
      32'(WINDOW_DAYS * HOURS_PER_DAY * SECS_PER_HOUR * MS_PER_SEC);

   // request opcodes
   localparam logic [2:0] OP_TICK         = 3'd0;
   localparam logic [2:0] OP_ARM_DELAY    = 3'd1;
   localparam logic [2:0] OP_ARM_INTERVAL = 3'd2;
   localparam logic [2:0] OP_RM_DELAY     = 3'd3;
   localparam logic [2:0] OP_RM_INTERVAL  = 3'd4;

   // response event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_DELAY    = 3'd1;
   localparam logic [2:0] EV_INTERVAL = 3'd2;
   localparam logic [2:0] EV_ARMED    = 3'd3;
   localparam logic [2:0] EV_REMOVED  = 3'd4;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_PEND_LAST,
      EMIT_QUIET,
      EMIT_ARMED,
      EMIT_FULL,
      EMIT_REMOVE,
      EMIT_BAD_OP
   } emit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TICK_RD,
      ST_TICK_EVAL,
      ST_TICK_END,
      ST_ARM_SCAN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic     load;
      logic     idx_inc;
      logic     pass_next;
      logic     mem_rd;
      logic     fire;
      emit_type emit_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       cand;
      logic       due;
      logic       pend_valid;
      logic       cnt_full;
      logic       idx_last;
      logic       pass;
      logic       out_free;
      logic       slot_free;
   } status_type;

endpackage

FILE: rtl/stt_ctrl.sv
module stt_ctrl import stt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      adv       = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.opcode == OP_TICK) begin
               state_in = ST_TICK_RD;
            end else if (sts.opcode inside {OP_ARM_DELAY, OP_ARM_INTERVAL}) begin
               state_in = ST_ARM_SCAN;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_TICK_RD: begin
            if (sts.cnt_full) begin
               state_in = ST_TICK_END;
            end else if (sts.cand) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_TICK_EVAL;
            end else begin
               adv = 1'b1;
            end
         end
         ST_TICK_EVAL: begin
            if (!sts.due) begin
               adv = 1'b1;
            end else if (!sts.pend_valid || sts.out_free) begin
               // pending hit moves out, this hit becomes pending
               cmd.fire = 1'b1;
               adv      = 1'b1;
            end
         end
         ST_TICK_END: begin
            if (sts.out_free) begin
               cmd.emit_sel = sts.pend_valid ? EMIT_PEND_LAST : EMIT_QUIET;
               state_in     = ST_IDLE;
            end
         end
         ST_ARM_SCAN: begin
            if (sts.slot_free) begin
               if (sts.out_free) begin
                  cmd.emit_sel = EMIT_ARMED;
                  state_in     = ST_IDLE;
               end
            end else if (sts.idx_last) begin
               if (sts.out_free) begin
                  cmd.emit_sel = EMIT_FULL;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_REPLY: begin
            if (sts.out_free) begin
               if (sts.opcode inside {OP_RM_DELAY, OP_RM_INTERVAL}) begin
                  cmd.emit_sel = EMIT_REMOVE;
               end else begin
                  cmd.emit_sel = EMIT_BAD_OP;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step the scan: next slot, next pass, or wrap up
      if (adv) begin
         if (!sts.idx_last) begin
            cmd.idx_inc = 1'b1;
            state_in    = ST_TICK_RD;
         end else if (!sts.pass) begin
            cmd.pass_next = 1'b1;
            state_in      = ST_TICK_RD;
         end else begin
            state_in = ST_TICK_END;
         end
      end
   end

endmodule

FILE: rtl/stt_datapath.sv
`include "software_timer_table_defines.svh"

module stt_datapath import stt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_duration_ms,
   input  logic [3:0]  req_handle,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data,
   input  cmd_type     cmd,
   output status_type  sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_slot,
   output logic        rsp_ok,
   output logic        rsp_last
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // latched request
   logic [2:0]  op_ff;
   logic [31:0] now_ff;
   logic [31:0] dur_ff;
   logic [3:0]  handle_ff;

   logic [31:0] window_ff;

   logic [SLOTS-1:0] busy_ff;
   logic [SLOTS-1:0] periodic_ff;

   logic [31:0] deadline_mem [SLOTS];
   logic [31:0] period_mem   [SLOTS];
   logic [31:0] rd_deadline_ff;
   logic [31:0] rd_period_ff;

   logic [IW-1:0]    idx_ff;
   logic             pass_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic       pend_valid_ff;
   logic [2:0] pend_ev_ff;
   logic [3:0] pend_slot_ff;

   logic       rsp_valid_ff;
   logic [2:0] rsp_event_res_ff;
   logic [3:0] rsp_slot_ff;
   logic       rsp_ok_ff;
   logic       rsp_last_ff;

   logic [2:0] rsp_event_res_in;
   logic [3:0] rsp_slot_in;
   logic       rsp_ok_in;
   logic       rsp_last_in;
   logic       out_load;

   logic [IW+3:0] idx_wide;
   logic [3:0]    idx_slot;
   logic [IW+3:0] handle_wide;
   logic [IW-1:0] hidx;
   logic          rm_match;
   logic          mem_we;
   logic [31:0]   mem_wdata;

   assign idx_wide    = {4'b0, idx_ff};
   assign idx_slot    = idx_wide[3:0];
   assign handle_wide = {{IW{1'b0}}, handle_ff};
   assign hidx        = handle_wide[IW-1:0];
   assign rm_match    = (handle_wide < (IW + 4)'(SLOTS)) && busy_ff[hidx] &&
                        (periodic_ff[hidx] == (op_ff == OP_RM_INTERVAL));

   always_comb begin
      sts.opcode     = op_ff;
      sts.cand       = busy_ff[idx_ff] && (periodic_ff[idx_ff] == pass_ff);
      sts.due        = (now_ff - rd_deadline_ff) <= window_ff;
      sts.pend_valid = pend_valid_ff;
      sts.cnt_full   = (cnt_ff == CNT_W'(MAX_RESULTS));
      sts.idx_last   = (idx_ff == IW'(SLOTS - 1));
      sts.pass       = pass_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
      sts.slot_free  = !busy_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         now_ff    <= req_now_ms;
         dur_ff    <= req_duration_ms;
         handle_ff <= req_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write_en) begin
         window_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= '0;
         periodic_ff <= '0;
      end else begin
         if (cmd.emit_sel == EMIT_ARMED) begin
            busy_ff[idx_ff]     <= 1'b1;
            periodic_ff[idx_ff] <= (op_ff == OP_ARM_INTERVAL);
         end
         if (cmd.emit_sel == EMIT_REMOVE && rm_match) begin
            busy_ff[hidx]     <= 1'b0;
            periodic_ff[hidx] <= 1'b0;
         end
         if (cmd.fire && !pass_ff) begin
            busy_ff[idx_ff] <= 1'b0;
         end
      end
   end

   // one write port: arm loads deadline, interval hit reloads it
   assign mem_we    = (cmd.emit_sel == EMIT_ARMED) || (cmd.fire && pass_ff);
   assign mem_wdata = (cmd.emit_sel == EMIT_ARMED) ? now_ff + dur_ff
                                                   : now_ff + rd_period_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[idx_ff] <= mem_wdata;
      end
      if (cmd.emit_sel == EMIT_ARMED) begin
         period_mem[idx_ff] <= dur_ff;
      end
      if (cmd.mem_rd) begin
         rd_deadline_ff <= deadline_mem[idx_ff];
         rd_period_ff   <= period_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pass_ff       <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         idx_ff        <= '0;
         pass_ff       <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.pass_next) begin
            idx_ff  <= '0;
            pass_ff <= 1'b1;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.fire) begin
            cnt_ff        <= cnt_ff + 1'b1;
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         pend_ev_ff   <= pass_ff ? EV_INTERVAL : EV_DELAY;
         pend_slot_ff <= idx_slot;
      end
   end

   always_comb begin
      rsp_event_res_in = EV_NONE;
      rsp_slot_in      = '0;
      rsp_ok_in        = 1'b1;
      rsp_last_in      = 1'b1;
      case (cmd.emit_sel)
         EMIT_PEND_LAST: begin
            rsp_event_res_in = pend_ev_ff;
            rsp_slot_in      = pend_slot_ff;
         end
         EMIT_QUIET: begin
            rsp_event_res_in = EV_NONE;
         end
         EMIT_ARMED: begin
            rsp_event_res_in = EV_ARMED;
            rsp_slot_in      = idx_slot;
         end
         EMIT_FULL: begin
            rsp_event_res_in = EV_ARMED;
            rsp_ok_in        = 1'b0;
         end
         EMIT_REMOVE: begin
            rsp_event_res_in = EV_REMOVED;
            rsp_slot_in      = handle_ff;
            rsp_ok_in        = rm_match;
         end
         EMIT_BAD_OP: begin
            rsp_ok_in = 1'b0;
         end
         default: begin
            // older hit leaves while a newer one is held back
            rsp_event_res_in = pend_ev_ff;
            rsp_slot_in      = pend_slot_ff;
            rsp_last_in      = 1'b0;
         end
      endcase
   end

   assign out_load = (cmd.emit_sel != EMIT_NONE) || (cmd.fire && pend_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_event_res_ff <= rsp_event_res_in;
         rsp_slot_ff      <= rsp_slot_in;
         rsp_ok_ff        <= rsp_ok_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_res_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_last      = rsp_last_ff;

   `STT_ASSERT_IMP(a_out_room, out_load, sts.out_free, "response overwrote a waiting transaction")
   `STT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_RESULTS), "too many hits in one tick")
   `STT_ASSERT_NXT(a_delay_freed, cmd.fire && !pass_ff, !busy_ff[$past(idx_ff)], "fired delay still busy")
   `STT_ASSERT_NXT(a_arm_busy, cmd.emit_sel == EMIT_ARMED, busy_ff[$past(idx_ff)], "armed slot not busy")

endmodule

FILE: rtl/software_timer_table.sv
// Channel   Ports                                           Direction
// request   req_valid/req_stall, opcode now_ms dur handle   in
// response  rsp_valid/rsp_stall, event_res slot ok last     out
// csr       csr_write_en, csr_write_data (future window)    in, write only
//
// One request at a time. Tick: each slot is looked at once per pass (delays,
//   then intervals); a slot that is a candidate takes a registered deadline
//   memory read, then a compare. Arm scans the slots in order for a free one.
// Reset: synchronous; slot flags clear at once, no sweep.
// Response stall holds the block wherever a response has to be written while
//   the output register is still full: a hit leaving mid-scan, or the final
//   response of a transaction.
module software_timer_table import stt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_duration_ms,
   input  logic [3:0]  req_handle,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_slot,
   output logic        rsp_ok,
   output logic        rsp_last,
   // configuration
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);

   cmd_type    cmd;
   status_type sts;

   // sequencer: decodes the transaction and walks the slot scan
   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot flags, deadline/period memories, output register; a finished hit
   // is held in a pending register so the final response of a tick can carry last
   stt_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_opcode      (req_opcode),
      .req_now_ms      (req_now_ms),
      .req_duration_ms (req_duration_ms),
      .req_handle      (req_handle),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_slot        (rsp_slot),
      .rsp_ok          (rsp_ok),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

import stt_pkg::*;

// One response transaction as the table reports it.
typedef struct packed {
   logic [2:0] event_res;
   logic [3:0] slot;
   logic       ok;
   logic       last;
} timer_event_type;

// Shadow copy of the timer table. Every accepted request transaction is applied
// here and the responses it must cause are queued in order; each response
// transaction from the block is checked against the oldest entry.
class timer_slot_tracker;
   localparam int NUM_SLOTS = SLOTS_DEFAULT;

   logic [31:0]     window;
   bit              busy     [NUM_SLOTS];
   bit              periodic [NUM_SLOTS];
   logic [31:0]     deadline [NUM_SLOTS];
   logic [31:0]     period_ms[NUM_SLOTS];
   timer_event_type pending_events[$];

   function new();
      window = WINDOW_RESET;
      foreach (busy[i]) begin
         busy[i]      = 1'b0;
         periodic[i]  = 1'b0;
         deadline[i]  = '0;
         period_ms[i] = '0;
      end
   endfunction

   function int pending();
      return pending_events.size();
   endfunction

   function bit is_due(logic [31:0] now, int i);
      logic [31:0] diff;
      diff = now - deadline[i];
      return diff <= window;
   endfunction

   function timer_event_type make_event(logic [2:0] ev, int s, bit ok);
      timer_event_type e;
      e.event_res = ev;
      e.slot      = 4'(s);
      e.ok        = ok;
      e.last      = 1'b0;
      return e;
   endfunction

   // Random busy slot of the given kind (-1 any, 0 delay, 1 interval), or -1.
   function int pick_busy(int kind);
      int hits[$];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (busy[i] && (kind < 0 || int'(periodic[i]) == kind))
            hits.push_back(i);
      if (hits.size() == 0)
         return -1;
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   function void note_request(logic [2:0] op, logic [31:0] now, logic [31:0] dur,
                              logic [3:0] hdl);
      timer_event_type out_q[$];
      int found;
      found = -1;
      case (op)
         OP_TICK: begin
            // delays first, then intervals, each in slot order
            for (int i = 0; i < NUM_SLOTS && out_q.size() < MAX_RESULTS; i++)
               if (busy[i] && !periodic[i] && is_due(now, i)) begin
                  busy[i] = 1'b0;
                  out_q.push_back(make_event(EV_DELAY, i, 1'b1));
               end
            for (int i = 0; i < NUM_SLOTS && out_q.size() < MAX_RESULTS; i++)
               if (busy[i] && periodic[i] && is_due(now, i)) begin
                  deadline[i] = now + period_ms[i];
                  out_q.push_back(make_event(EV_INTERVAL, i, 1'b1));
               end
            if (out_q.size() == 0)
               out_q.push_back(make_event(EV_NONE, 0, 1'b1));
         end
         OP_ARM_DELAY, OP_ARM_INTERVAL: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (!busy[i] && found < 0)
                  found = i;
            if (found >= 0) begin
               busy[found]      = 1'b1;
               periodic[found]  = (op == OP_ARM_INTERVAL);
               deadline[found]  = now + dur;
               period_ms[found] = dur;
               out_q.push_back(make_event(EV_ARMED, found, 1'b1));
            end else begin
               out_q.push_back(make_event(EV_ARMED, 0, 1'b0));
            end
         end
         OP_RM_DELAY, OP_RM_INTERVAL: begin
            if (busy[hdl] && periodic[hdl] == (op == OP_RM_INTERVAL)) begin
               busy[hdl]     = 1'b0;
               periodic[hdl] = 1'b0;
               out_q.push_back(make_event(EV_REMOVED, hdl, 1'b1));
            end else begin
               out_q.push_back(make_event(EV_REMOVED, hdl, 1'b0));
            end
         end
         default:
            out_q.push_back(make_event(EV_NONE, 0, 1'b0));
      endcase
      out_q[out_q.size() - 1].last = 1'b1;
      foreach (out_q[k])
         pending_events.push_back(out_q[k]);
   endfunction

   // Empty string when the response matches the oldest expectation.
   function string check_result(timer_event_type got);
      timer_event_type want;
      if (pending_events.size() == 0)
         return $sformatf("unexpected response ev=%0d slot=%0d ok=%0b last=%0b",
                          got.event_res, got.slot, got.ok, got.last);
      want = pending_events.pop_front();
      if (got.event_res !== want.event_res || got.slot !== want.slot ||
          got.ok !== want.ok || got.last !== want.last)
         return $sformatf("response ev/slot/ok/last got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
                          got.event_res, got.slot, got.ok, got.last,
                          want.event_res, want.slot, want.ok, want.last);
      return "";
   endfunction
endclass

module testbench;

   // Unused opcodes, which the block answers with a failed response.
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 8;     // quiet time before a CSR write
   localparam int DRAIN_CYCLES  = 80;    // outlasts one full tick scan
   localparam int HOLD_CYCLES   = 400;   // long response back-pressure stretch
   localparam int STUCK_LIMIT   = 3000;  // cycles without any transaction

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_TICK;
   logic [31:0] req_now_ms = '0;
   logic [31:0] req_duration_ms = '0;
   logic [3:0]  req_handle = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic [3:0]  rsp_slot;
   logic        rsp_ok;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   timer_slot_tracker tracker = new();

   int              fail_count    = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_trigger  = 0;   // bumped by the stimulus to start a hold
   int              hold_seen     = 0;
   int              hold_left     = 0;
   int              stuck_cycles  = 0;
   logic [31:0]     cur_now       = '0;
   timer_event_type mon_got;
   string           mon_msg;

   software_timer_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_now_ms      (req_now_ms),
      .req_duration_ms (req_duration_ms),
      .req_handle      (req_handle),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_res   (rsp_event_res),
      .rsp_slot        (rsp_slot),
      .rsp_ok          (rsp_ok),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      fail_count++;
   endtask

   // Receiver side: random stall, or a long hold once the stimulus asks for one.
   // The hold is counted here so only this process drives rsp_stall.
   always @(negedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Response monitor: every accepted response transaction is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         mon_got.event_res = rsp_event_res;
         mon_got.slot      = rsp_slot;
         mon_got.ok        = rsp_ok;
         mon_got.last      = rsp_last;
         mon_msg = tracker.check_result(mon_got);
         if (mon_msg != "")
            report_mismatch(mon_msg);
      end
   end

   // Watchdog: ends the run when no transaction moves on either channel for
   // too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offers one request transaction and returns at the falling edge after it
   // was taken. Starts and ends on a falling edge; valid stays high between
   // back-to-back requests.
   task automatic send_item(input logic [2:0] op, input logic [31:0] now,
                            input logic [31:0] dur, input logic [3:0] hdl);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_now_ms      <= now;
      req_duration_ms <= dur;
      req_handle      <= hdl;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      tracker.note_request(op, now, dur, hdl);
      @(negedge clock);
   endtask

   // Sender goes quiet until every expected response has come back.
   task automatic drain_all();
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_window(input logic [31:0] value);
      drain_all();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      tracker.window = value;
   endtask

   // Random traffic. Time mostly creeps forward so armed slots come due; now
   // and then it jumps anywhere to exercise wrap. Removes mostly hit a live
   // slot of the right kind, ticks sometimes land exactly on a deadline.
   // Unused opcodes are mixed in but not counted.
   task automatic run_random(input int n_items);
      int          done_cnt;
      int          pick;
      int          s;
      logic [2:0]  op;
      logic [31:0] now;
      logic [31:0] dur;
      logic [3:0]  hdl;
      done_cnt = 0;
      while (done_cnt < n_items) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0)
            cur_now = $urandom;
         else
            cur_now = cur_now + $urandom_range(0, 60);
         now = cur_now;
         dur = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 150);
         hdl = 4'($urandom_range(0, 15));
         if (pick < 32)
            op = OP_TICK;
         else if (pick < 52)
            op = OP_ARM_DELAY;
         else if (pick < 70)
            op = OP_ARM_INTERVAL;
         else if (pick < 82)
            op = OP_RM_DELAY;
         else if (pick < 96)
            op = OP_RM_INTERVAL;
         else
            op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         if (op == OP_RM_DELAY || op == OP_RM_INTERVAL) begin
            s = tracker.pick_busy(op == OP_RM_INTERVAL);
            if (s >= 0 && $urandom_range(0, 4) != 0)
               hdl = 4'(s);
         end
         if (op == OP_TICK && $urandom_range(0, 3) == 0) begin
            s = tracker.pick_busy(-1);
            if (s >= 0)
               now = tracker.deadline[s];
         end
         send_item(op, now, dur, hdl);
         if (op <= OP_RM_INTERVAL)
            done_cnt++;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: window at reset value; sender idles a little, receiver a lot.
      send_idle_pct = 16;
      recv_idle_pct = 62;

      // Directed: quiet tick, unused opcodes, remove of a free slot,
      // zero duration, full-range time, removes of the wrong kind.
      send_item(OP_TICK, 32'd0, 32'd0, 4'd0);
      send_item(OP_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      send_item(OP_UNUSED_HI, 32'd0, 32'd0, 4'd0);
      send_item(OP_RM_DELAY, 32'd0, 32'd0, 4'hF);
      send_item(OP_ARM_DELAY, 32'hFFFF_FFFF, 32'd0, 4'd0);
      send_item(OP_ARM_INTERVAL, 32'd0, 32'hFFFF_FFFF, 4'd0);
      send_item(OP_RM_INTERVAL, 32'd0, 32'd0, 4'd0);
      send_item(OP_RM_DELAY, 32'd0, 32'd0, 4'd1);
      // fill the rest of the table, then one arm too many
      for (int i = 2; i < 16; i++)
         send_item((i % 2) ? OP_ARM_INTERVAL : OP_ARM_DELAY, 32'd100, 32'(10 * i), 4'd0);
      send_item(OP_ARM_DELAY, 32'd100, 32'd5, 4'd0);
      // every slot due at once (slots 0/1 across the wrap): 16 responses
      send_item(OP_TICK, 32'd1000, 32'd0, 4'd0);
      send_item(OP_RM_INTERVAL, 32'd0, 32'd0, 4'd1);

      run_random(50);

      // Phase 2: zero window, only exact deadlines count; roles swapped.
      write_window(32'd0);
      send_idle_pct = 62;
      recv_idle_pct = 16;
      run_random(38);

      // Phase 3: widest window, every busy slot due on every tick; no idling.
      write_window(32'hFFFF_FFFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(25);

      // Phase 4: narrow random window. Receiver holds off for a long stretch
      // while requests keep coming so the block backs up into req_stall, then
      // the sender waits for everything to drain before going on.
      write_window($urandom_range(1000, 1000000));
      hold_trigger++;
      run_random(17);
      drain_all();
      run_random(15);

      drain_all();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_ctrl.sv
rtl/stt_datapath.sv
rtl/software_timer_table.sv
tb/sv/testbench.sv
